>>> rtl/core/acpwm_pkg.sv
// shared types and constants of the averaged current pi pwm loop
package acpwm_pkg;

	localparam int SAMPLE_W = 12;
	localparam int PADDR_W  = 5;
	localparam int PDATA_W  = 32;

	// register indexes on the configuration port
	typedef enum logic [2:0] {
		REG_TARGET = 3'd0,
		REG_PROP   = 3'd1,
		REG_INTEG  = 3'd2,
		REG_OFFSET = 3'd3,
		REG_SCALE  = 3'd4,
		REG_ICPT   = 3'd5,
		REG_PERIOD = 3'd6
	} reg_idx_t;

	localparam logic [19:0] TARGET_RST = 20'd26214;
	localparam logic [15:0] PROP_RST   = 16'd2560;
	localparam logic [15:0] INTEG_RST  = 16'd786;
	localparam logic [15:0] OFFSET_RST = 16'd0;
	localparam logic [15:0] SCALE_RST  = 16'd10846;
	localparam logic [19:0] ICPT_RST   = 20'hFF127;
	localparam logic [15:0] PERIOD_RST = 16'd300;

	// duty in percent, q.16
	localparam logic [22:0] DUTY_MAX  = 23'd6291456;
	localparam logic [22:0] DUTY_ONE  = 23'd65536;
	localparam logic [22:0] DUTY_FULL = 23'd6553600;

	localparam logic signed [20:0] ERR_RST = 21'sd65536;

	localparam logic signed [22:0] CUR_MAX = 23'sd524287;
	localparam logic signed [22:0] CUR_MIN = -23'sd524288;

	// floor(y / 100) = (y * DIV100_M) >> 30 for y below 2^23
	localparam logic [23:0] DIV100_M = 24'd10737419;

	typedef struct packed {
		logic [19:0] target;
		logic [15:0] prop;
		logic [15:0] integ;
		logic [15:0] offset;
		logic [15:0] scale;
		logic [19:0] icpt;
		logic [15:0] period;
	} cfg_t;

	// datapath steps issued by the sequencer
	typedef enum logic [3:0] {
		OP_NONE = 4'd0,
		OP_SUM  = 4'd1,
		OP_MEAN = 4'd2,
		OP_CURM = 4'd3,
		OP_CUR  = 4'd4,
		OP_ERR  = 4'd5,
		OP_PMUL = 4'd6,
		OP_IMUL = 4'd7,
		OP_DUTY = 4'd8,
		OP_CMUL = 4'd9,
		OP_DMUL = 4'd10,
		OP_OUT  = 4'd11
	} op_t;

	typedef struct packed {
		logic take;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} stat_t;

endpackage

>>> rtl/core/acpwm_regs.sv
// configuration register file on the apb-style port
module acpwm_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [acpwm_pkg::PADDR_W-1:0]     paddr,
	input  logic [acpwm_pkg::PDATA_W-1:0]     pwdata,
	output logic [acpwm_pkg::PDATA_W-1:0]     prdata,
	output logic                              pready,
	output acpwm_pkg::cfg_t                   cfg
);

	acpwm_pkg::cfg_t      cfg_q;
	acpwm_pkg::reg_idx_t  idx;
	logic                 wr_en;

	assign idx    = acpwm_pkg::reg_idx_t'(paddr[acpwm_pkg::PADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target <= acpwm_pkg::TARGET_RST;
			cfg_q.prop   <= acpwm_pkg::PROP_RST;
			cfg_q.integ  <= acpwm_pkg::INTEG_RST;
			cfg_q.offset <= acpwm_pkg::OFFSET_RST;
			cfg_q.scale  <= acpwm_pkg::SCALE_RST;
			cfg_q.icpt   <= acpwm_pkg::ICPT_RST;
			cfg_q.period <= acpwm_pkg::PERIOD_RST;
		end else if (wr_en) begin
			case (idx)
				acpwm_pkg::REG_TARGET: cfg_q.target <= pwdata[19:0];
				acpwm_pkg::REG_PROP:   cfg_q.prop   <= pwdata[15:0];
				acpwm_pkg::REG_INTEG:  cfg_q.integ  <= pwdata[15:0];
				acpwm_pkg::REG_OFFSET: cfg_q.offset <= pwdata[15:0];
				acpwm_pkg::REG_SCALE:  cfg_q.scale  <= pwdata[15:0];
				acpwm_pkg::REG_ICPT:   cfg_q.icpt   <= pwdata[19:0];
				acpwm_pkg::REG_PERIOD: cfg_q.period <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			acpwm_pkg::REG_TARGET: prdata = {12'd0, cfg_q.target};
			acpwm_pkg::REG_PROP:   prdata = {16'd0, cfg_q.prop};
			acpwm_pkg::REG_INTEG:  prdata = {16'd0, cfg_q.integ};
			acpwm_pkg::REG_OFFSET: prdata = {16'd0, cfg_q.offset};
			acpwm_pkg::REG_SCALE:  prdata = {16'd0, cfg_q.scale};
			acpwm_pkg::REG_ICPT:   prdata = {12'd0, cfg_q.icpt};
			acpwm_pkg::REG_PERIOD: prdata = {16'd0, cfg_q.period};
			default:               prdata = '0;
		endcase
	end

endmodule

>>> rtl/core/acpwm_ctrl.sv
// sequencer that steps the datapath through one sample
module acpwm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output acpwm_pkg::cmd_t  cmd,
	input  acpwm_pkg::stat_t stat
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SUM,
		ST_MEAN,
		ST_CURM,
		ST_CUR,
		ST_ERR,
		ST_PMUL,
		ST_IMUL,
		ST_DUTY,
		ST_CMUL,
		ST_DMUL,
		ST_OUT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_MEAN;
				ST_MEAN: state_q <= ST_CURM;
				ST_CURM: state_q <= ST_CUR;
				ST_CUR:  state_q <= ST_ERR;
				ST_ERR:  state_q <= ST_PMUL;
				ST_PMUL: state_q <= ST_IMUL;
				ST_IMUL: state_q <= ST_DUTY;
				ST_DUTY: state_q <= ST_CMUL;
				ST_CMUL: state_q <= ST_DMUL;
				ST_DMUL: state_q <= ST_OUT;
				ST_OUT:  if (stat.out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd.take = (state_q == ST_IDLE) && in_valid;
		case (state_q)
			ST_SUM:  cmd.op = acpwm_pkg::OP_SUM;
			ST_MEAN: cmd.op = acpwm_pkg::OP_MEAN;
			ST_CURM: cmd.op = acpwm_pkg::OP_CURM;
			ST_CUR:  cmd.op = acpwm_pkg::OP_CUR;
			ST_ERR:  cmd.op = acpwm_pkg::OP_ERR;
			ST_PMUL: cmd.op = acpwm_pkg::OP_PMUL;
			ST_IMUL: cmd.op = acpwm_pkg::OP_IMUL;
			ST_DUTY: cmd.op = acpwm_pkg::OP_DUTY;
			ST_CMUL: cmd.op = acpwm_pkg::OP_CMUL;
			ST_DMUL: cmd.op = acpwm_pkg::OP_DMUL;
			// result register must be free before the final load
			ST_OUT:  cmd.op = stat.out_free ? acpwm_pkg::OP_OUT : acpwm_pkg::OP_NONE;
			default: cmd.op = acpwm_pkg::OP_NONE;
		endcase
	end

endmodule

>>> rtl/core/acpwm_dp.sv
// datapath: sample ring, running sum, shared multiplier, pi update and result register
module acpwm_dp #(
	parameter int WINDOW_DEPTH  = 16,
	parameter int STARTUP_STEPS = 50
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  acpwm_pkg::cmd_t                     cmd,
	output acpwm_pkg::stat_t                    stat,
	input  acpwm_pkg::cfg_t                     cfg,
	input  logic [acpwm_pkg::SAMPLE_W-1:0]      sample,
	input  logic                                out_stall,
	output logic                                out_valid,
	output logic [15:0]                         compare_value,
	output logic [22:0]                         duty_percent,
	output logic signed [19:0]                  measured_current
);

	localparam int IDX_W  = $clog2(WINDOW_DEPTH);
	localparam int SUM_W  = acpwm_pkg::SAMPLE_W + IDX_W;
	localparam int NUM_W  = SUM_W + 4;
	localparam int MEAN_K = NUM_W + IDX_W;
	// floor(num / WINDOW_DEPTH) = (num * MEAN_M) >> MEAN_K for num below 2^NUM_W
	localparam longint MEAN_M = ((longint'(1) << MEAN_K) + WINDOW_DEPTH - 1) / WINDOW_DEPTH;
	localparam int MW     = (NUM_W + 2 > 25) ? NUM_W + 2 : 25;
	localparam int PW     = 2 * MW;
	localparam int CNT_W  = $clog2(STARTUP_STEPS + 1);

	// sample ring with per-entry valid bits, an invalid entry reads as zero
	logic [acpwm_pkg::SAMPLE_W-1:0] ring_mem [WINDOW_DEPTH];
	logic [WINDOW_DEPTH-1:0]        ring_vld_q;

	logic [IDX_W-1:0]               idx_q;
	logic [SUM_W-1:0]               sum_q;
	logic signed [20:0]             prev_q;
	logic [22:0]                    duty_q;
	logic [CNT_W-1:0]               cnt_q;
	logic                           out_valid_q;

	logic [acpwm_pkg::SAMPLE_W-1:0] sample_q;
	logic [acpwm_pkg::SAMPLE_W-1:0] old_q;
	logic                           old_vld_q;
	logic signed [PW-1:0]           prod_q;
	logic signed [19:0]             cur_q;
	logic signed [20:0]             err_q;
	logic signed [21:0]             diff_q;
	logic signed [30:0]             pterm_q;
	logic [15:0]                    cmp_out_q;
	logic [22:0]                    duty_out_q;
	logic signed [19:0]             cur_out_q;

	logic [acpwm_pkg::SAMPLE_W-1:0] old_eff;
	logic signed [MW-1:0]           mul_a;
	logic signed [MW-1:0]           mul_b;
	logic signed [PW-1:0]           prod_d;
	logic                           mul_en;
	logic [15:0]                    mean;
	logic signed [17:0]             ofs_sum;
	logic signed [22:0]             cur_raw;
	logic signed [19:0]             cur_sat;
	logic signed [20:0]             err_d;
	logic signed [21:0]             diff_d;
	logic signed [21:0]             iterm;
	logic signed [32:0]             duty_sum;
	logic [CNT_W-1:0]               cnt_inc;
	logic                           in_startup;
	logic [22:0]                    duty_d;
	logic [CNT_W-1:0]               cnt_d;
	logic [22:0]                    cmp_base;

	assign old_eff = old_vld_q ? old_q : '0;

	// mean of the window in q.16 of full scale, then offset
	assign mean    = prod_q[MEAN_K +: 16];
	assign ofs_sum = $signed({2'b00, mean}) + $signed({{2{cfg.offset[15]}}, cfg.offset});

	// floor by arithmetic shift, then intercept and saturation
	assign cur_raw = $signed({prod_q[33], prod_q[33:12]})
		+ $signed({{3{cfg.icpt[19]}}, cfg.icpt});

	always_comb begin
		if (cur_raw > acpwm_pkg::CUR_MAX) begin
			cur_sat = acpwm_pkg::CUR_MAX[19:0];
		end else if (cur_raw < acpwm_pkg::CUR_MIN) begin
			cur_sat = acpwm_pkg::CUR_MIN[19:0];
		end else begin
			cur_sat = cur_raw[19:0];
		end
	end

	assign err_d  = $signed({cfg.target[19], cfg.target}) - $signed({cur_q[19], cur_q});
	assign diff_d = $signed({err_d[20], err_d}) - $signed({prev_q[20], prev_q});

	assign iterm    = prod_q[37:16];
	assign duty_sum = $signed({10'd0, duty_q})
		+ $signed({{2{pterm_q[30]}}, pterm_q})
		+ $signed({{11{iterm[21]}}, iterm});

	assign cnt_inc    = (cnt_q < CNT_W'(STARTUP_STEPS)) ? cnt_q + CNT_W'(1) : cnt_q;
	assign in_startup = (cnt_inc < CNT_W'(STARTUP_STEPS));

	always_comb begin
		duty_d = duty_sum[22:0];
		cnt_d  = cnt_inc;
		if (duty_sum > $signed({10'd0, acpwm_pkg::DUTY_MAX})) begin
			if (in_startup) begin
				// overshoot during startup restarts from one percent and ends startup
				duty_d = acpwm_pkg::DUTY_ONE;
				cnt_d  = CNT_W'(STARTUP_STEPS);
			end else begin
				duty_d = acpwm_pkg::DUTY_MAX;
			end
		end else if (duty_sum < 0) begin
			duty_d = '0;
		end
	end

	assign cmp_base = acpwm_pkg::DUTY_FULL - duty_q;

	// shared multiplier operand selection
	always_comb begin
		mul_en = cmd.op inside {acpwm_pkg::OP_MEAN, acpwm_pkg::OP_CURM, acpwm_pkg::OP_PMUL,
			acpwm_pkg::OP_IMUL, acpwm_pkg::OP_CMUL, acpwm_pkg::OP_DMUL};
		case (cmd.op)
			acpwm_pkg::OP_MEAN: begin
				mul_a = $signed({{(MW-NUM_W){1'b0}}, sum_q, 4'b0000});
				mul_b = $signed(MW'(MEAN_M));
			end
			acpwm_pkg::OP_CURM: begin
				mul_a = $signed({{(MW-18){ofs_sum[17]}}, ofs_sum});
				mul_b = $signed({{(MW-16){1'b0}}, cfg.scale});
			end
			acpwm_pkg::OP_PMUL: begin
				mul_a = $signed({{(MW-22){diff_q[21]}}, diff_q});
				mul_b = $signed({{(MW-16){1'b0}}, cfg.prop});
			end
			acpwm_pkg::OP_IMUL: begin
				mul_a = $signed({{(MW-21){err_q[20]}}, err_q});
				mul_b = $signed({{(MW-16){1'b0}}, cfg.integ});
			end
			acpwm_pkg::OP_CMUL: begin
				mul_a = $signed({{(MW-23){1'b0}}, cmp_base});
				mul_b = $signed({{(MW-16){1'b0}}, cfg.period});
			end
			acpwm_pkg::OP_DMUL: begin
				// drop the q.16 fraction, then divide by 100
				mul_a = $signed({{(MW-23){1'b0}}, prod_q[38:16]});
				mul_b = $signed({{(MW-24){1'b0}}, acpwm_pkg::DIV100_M});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_d = mul_a * mul_b;

	// ring memory, no reset
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			old_q     <= ring_mem[idx_q];
			old_vld_q <= ring_vld_q[idx_q];
			sample_q  <= sample;
		end
		if (cmd.op == acpwm_pkg::OP_SUM) begin
			ring_mem[idx_q] <= sample_q;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= prod_d;
		end
		if (cmd.op == acpwm_pkg::OP_CUR) begin
			cur_q <= cur_sat;
		end
		if (cmd.op == acpwm_pkg::OP_ERR) begin
			err_q  <= err_d;
			diff_q <= diff_d;
		end
		if (cmd.op == acpwm_pkg::OP_IMUL) begin
			pterm_q <= prod_q[38:8];
		end
		if (cmd.op == acpwm_pkg::OP_OUT) begin
			cmp_out_q  <= prod_q[45:30];
			duty_out_q <= duty_q;
			cur_out_q  <= cur_q;
		end
	end

	// loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_vld_q  <= '0;
			idx_q       <= '0;
			sum_q       <= '0;
			prev_q      <= acpwm_pkg::ERR_RST;
			duty_q      <= acpwm_pkg::DUTY_ONE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == acpwm_pkg::OP_SUM) begin
				ring_vld_q[idx_q] <= 1'b1;
				sum_q <= sum_q - SUM_W'(old_eff) + SUM_W'(sample_q);
				idx_q <= (idx_q == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : idx_q + IDX_W'(1);
			end
			if (cmd.op == acpwm_pkg::OP_DUTY) begin
				duty_q <= duty_d;
				cnt_q  <= cnt_d;
				prev_q <= err_q;
			end
			if (cmd.op == acpwm_pkg::OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.out_free    = !out_valid_q || !out_stall;
	assign out_valid        = out_valid_q;
	assign compare_value    = cmp_out_q;
	assign duty_percent     = duty_out_q;
	assign measured_current = cur_out_q;

	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		duty_q <= acpwm_pkg::DUTY_MAX)
		else $error("duty above the clamp limit");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(STARTUP_STEPS))
		else $error("startup count past its end");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IDX_W'(WINDOW_DEPTH - 1))
		else $error("ring index out of range");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == acpwm_pkg::OP_OUT) |=> out_valid_q && (duty_out_q == $past(duty_q)))
		else $error("result register not loaded by the final step");

endmodule

>>> rtl/core/averaged_current_pi_pwm_loop.sv
// top level of the averaged current pi loop with pwm compare output
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------------
//  input    | in_valid / in_stall  | sample
//  result   | out_valid/ out_stall | compare_value, duty_percent, measured_current
//  config   | psel/penable/pwrite  | paddr, pwdata, prdata (pready tied high)
//
//  one item is the transfer, then 11 sequencer steps, six of which
//  share the single 25x25 multiplier (window mean, current, p term, i term, compare, /100)
//  a result waits in the output register; the next sample transfer is taken meanwhile
//  the last step holds only while the output register is still full and stalled
//  reset clears the ring valid bits at once, so no clearing pass is needed
module averaged_current_pi_pwm_loop #(
	parameter int WINDOW_DEPTH  = 16,
	parameter int STARTUP_STEPS = 50
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [acpwm_pkg::SAMPLE_W-1:0]    sample,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [15:0]                       compare_value,
	output logic [22:0]                       duty_percent,
	output logic signed [19:0]                measured_current,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [acpwm_pkg::PADDR_W-1:0]     paddr,
	input  logic [acpwm_pkg::PDATA_W-1:0]     pwdata,
	output logic [acpwm_pkg::PDATA_W-1:0]     prdata,
	output logic                              pready
);

	acpwm_pkg::cfg_t  cfg;
	acpwm_pkg::cmd_t  cmd;
	acpwm_pkg::stat_t stat;

	acpwm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	acpwm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.stat     (stat)
	);

	acpwm_dp #(
		.WINDOW_DEPTH  (WINDOW_DEPTH),
		.STARTUP_STEPS (STARTUP_STEPS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.cfg              (cfg),
		.sample           (sample),
		.out_stall        (out_stall),
		.out_valid        (out_valid),
		.compare_value    (compare_value),
		.duty_percent     (duty_percent),
		.measured_current (measured_current)
	);

endmodule

>>> tb/sv/tb.sv
// self-checking testbench for the averaged current pi loop with pwm compare output
module tb;

	localparam int WIN        = 16;
	localparam int STARTUP    = 50;
	localparam int SETTLE     = 24;
	localparam int LIMIT      = 200000;
	localparam int HOLD_LEN   = 200;
	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam longint FULL_Q16   = 64'sd6553600;
	localparam longint TOP_Q16    = 64'sd6291456;
	localparam longint ONE_Q16    = 64'sd65536;
	localparam longint AMPS_HI    = 64'sd524287;
	localparam longint AMPS_LO    = -64'sd524288;

	typedef struct {
		logic [15:0] cmp;
		logic [22:0] duty;
		logic [19:0] amps;
	} loop_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [11:0] sample = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] compare_value;
	logic [22:0] duty_percent;
	logic signed [19:0] measured_current;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [acpwm_pkg::PADDR_W-1:0] paddr = '0;
	logic [acpwm_pkg::PDATA_W-1:0] pwdata = '0;
	logic [acpwm_pkg::PDATA_W-1:0] prdata;
	logic        pready;

	averaged_current_pi_pwm_loop u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .sample(sample),
		.out_valid(out_valid), .out_stall(out_stall),
		.compare_value(compare_value), .duty_percent(duty_percent),
		.measured_current(measured_current),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state and register mirror
	acpwm_pkg::cfg_t cfg;
	logic [11:0] sample_hist [WIN];
	int          win_sum;
	int          slot;
	longint      last_err;
	longint      duty_q16;
	int          boot_steps;

	logic [11:0] feed_q [$];
	loop_out_t   predicted_q [$];

	int  send_idle = 0;
	int  recv_idle = 0;
	bit  sample_taken = 0;
	int  items_in = 0;
	int  results_seen = 0;
	int  errors = 0;
	int  cycles = 0;
	int  hold_at = -1;
	int  hold_left = 0;
	bit  hold_done = 0;
	int  stall_seen = 0;
	int  boot_trips = 0;
	int  amps_clips = 0;
	int  duty_clips = 0;
	int  level = 2048;

	task automatic advance_loop(input logic [11:0] s);
		longint    mean_fs, amps, err, pterm, iterm, duty_nx;
		bit        startup_open;
		loop_out_t r;
		win_sum = win_sum - int'(sample_hist[slot]) + int'(s);
		sample_hist[slot] = s;
		slot = (slot == WIN - 1) ? 0 : slot + 1;
		mean_fs = (longint'(win_sum) * 16) / WIN;
		amps = (((mean_fs + longint'($signed(cfg.offset))) * longint'(cfg.scale)) >>> 12)
			+ longint'($signed(cfg.icpt));
		if (amps > AMPS_HI || amps < AMPS_LO)
			amps_clips++;
		if (amps > AMPS_HI)
			amps = AMPS_HI;
		if (amps < AMPS_LO)
			amps = AMPS_LO;
		if (boot_steps < STARTUP)
			boot_steps++;
		startup_open = boot_steps < STARTUP;
		err = longint'($signed(cfg.target)) - amps;
		pterm = (longint'(cfg.prop) * (err - last_err)) >>> 8;
		iterm = (longint'(cfg.integ) * err) >>> 16;
		duty_nx = duty_q16 + pterm + iterm;
		last_err = err;
		if (duty_nx > TOP_Q16) begin
			if (startup_open) begin
				// overshoot while starting up drops back to one percent for good
				duty_nx = ONE_Q16;
				boot_steps = STARTUP;
				boot_trips++;
			end else begin
				duty_nx = TOP_Q16;
				duty_clips++;
			end
		end else if (duty_nx < 0) begin
			duty_nx = 0;
			duty_clips++;
		end
		duty_q16 = duty_nx;
		r.cmp  = 16'((longint'(cfg.period) * (FULL_Q16 - duty_nx)) / FULL_Q16);
		r.duty = duty_nx[22:0];
		r.amps = amps[19:0];
		predicted_q.push_back(r);
	endtask

	function automatic void check_field(input string name, input longint want,
		input longint got);
		if (want != got) begin
			$display("%0t %s expected %0d actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	// input transfer capture, result check and watchdog
	always @(posedge clk) begin
		loop_out_t e;
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("averaged_current_pi_pwm_loop: mismatch");
			$finish;
		end
		if (arst_n) begin
			if (in_valid && in_stall)
				stall_seen <= stall_seen + 1;
			if (out_valid && !out_stall) begin
				results_seen <= results_seen + 1;
				if (predicted_q.size() == 0) begin
					$display("%0t unexpected result cmp %0d duty %0d amps %0d", $time,
						compare_value, duty_percent, measured_current);
					errors++;
				end else begin
					e = predicted_q.pop_front();
					check_field("compare_value", e.cmp, compare_value);
					check_field("duty_percent", e.duty, duty_percent);
					check_field("measured_current", $signed(e.amps), measured_current);
				end
			end
			if (in_valid && !in_stall) begin
				advance_loop(sample);
				sample_taken = 1;
				items_in <= items_in + 1;
			end
		end
	end

	// long receiver hold-off, armed once by item count
	always @(posedge clk) begin
		if (hold_left != 0)
			hold_left <= hold_left - 1;
		else if (!hold_done && items_in == hold_at) begin
			hold_left <= HOLD_LEN;
			hold_done <= 1;
		end
	end

	always @(negedge clk) begin
		if (in_valid && !sample_taken) begin
			// stalled payload stays put
		end else if (feed_q.size() != 0 && $urandom_range(99) >= send_idle) begin
			in_valid <= 1'b1;
			sample <= feed_q.pop_front();
		end else begin
			in_valid <= 1'b0;
		end
		sample_taken = 0;
		out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle);
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			acpwm_pkg::REG_TARGET: cfg.target = val[19:0];
			acpwm_pkg::REG_PROP:   cfg.prop   = val[15:0];
			acpwm_pkg::REG_INTEG:  cfg.integ  = val[15:0];
			acpwm_pkg::REG_OFFSET: cfg.offset = val[15:0];
			acpwm_pkg::REG_SCALE:  cfg.scale  = val[15:0];
			acpwm_pkg::REG_ICPT:   cfg.icpt   = val[19:0];
			acpwm_pkg::REG_PERIOD: cfg.period = val[15:0];
			default: ;
		endcase
	endtask

	task automatic set_all(input logic [19:0] tgt, input logic [15:0] kp,
		input logic [15:0] ki, input logic [15:0] ofs, input logic [15:0] scl,
		input logic [19:0] icp, input logic [15:0] per);
		write_reg(acpwm_pkg::REG_TARGET, 32'(tgt));
		write_reg(acpwm_pkg::REG_PROP, 32'(kp));
		write_reg(acpwm_pkg::REG_INTEG, 32'(ki));
		write_reg(acpwm_pkg::REG_OFFSET, 32'(ofs));
		write_reg(acpwm_pkg::REG_SCALE, 32'(scl));
		write_reg(acpwm_pkg::REG_ICPT, 32'(icp));
		write_reg(acpwm_pkg::REG_PERIOD, 32'(per));
	endtask

	// wait until every queued sample has come back as a checked result
	task automatic drain();
		int want;
		want = results_seen + feed_q.size() + predicted_q.size();
		while (results_seen < want)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	function automatic logic [11:0] pick_sample();
		case ($urandom_range(3))
			0: return 12'($urandom);
			1: return $urandom_range(1) ? 12'hFFF : 12'h000;
			2: return 12'(1 << $urandom_range(11));
			default: begin
				// slowly wandering level, like a real current trace
				level = level + $urandom_range(128) - 64;
				if (level < 0)
					level = 0;
				if (level > 4095)
					level = 4095;
				return 12'(level);
			end
		endcase
	endfunction

	task automatic run_random(input int n);
		repeat (n) feed_q.push_back(pick_sample());
		drain();
	endtask

	initial begin
		cfg = '{target: acpwm_pkg::TARGET_RST, prop: acpwm_pkg::PROP_RST,
			integ: acpwm_pkg::INTEG_RST, offset: acpwm_pkg::OFFSET_RST,
			scale: acpwm_pkg::SCALE_RST, icpt: acpwm_pkg::ICPT_RST,
			period: acpwm_pkg::PERIOD_RST};
		foreach (sample_hist[i])
			sample_hist[i] = '0;
		win_sum = 0;
		slot = 0;
		last_err = 64'(acpwm_pkg::ERR_RST);
		duty_q16 = ONE_Q16;
		boot_steps = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		send_idle = 32;
		recv_idle = 82;
		// reset settings, field extremes and bit patterns
		feed_q = '{12'h000, 12'hFFF, 12'hAAA, 12'h555, 12'hFFF, 12'hFFF, 12'h000, 12'h001,
			12'h800, 12'hFFE};
		drain();

		// huge error with pure integral action: overshoot inside startup, then clamp at top
		set_all(20'h7FFFF, 16'd0, 16'hFFFF, 16'h0000, 16'd0, 20'h80000, 16'd1);
		repeat (15) feed_q.push_back(12'h000);
		drain();

		set_all(20'($urandom_range(200000)), 16'($urandom_range(4096)), 16'($urandom),
			16'($urandom_range(4000)), 16'($urandom), 20'($urandom), 16'($urandom_range(1, 65535)));
		run_random(130);

		send_idle = 82;
		recv_idle = 32;
		// top extremes: current clips high, gains maxed
		set_all(20'h80000, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'hFFFF, 20'h7FFFF, 16'hFFFF);
		run_random(130);

		send_idle = 0;
		recv_idle = 0;
		// bottom extremes: current clips low, zero period; unmapped address must not land
		set_all(20'h7FFFF, 16'd0, 16'd1, 16'h8000, 16'hFFFF, 20'h80000, 16'd0);
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		hold_at = items_in + 20;
		run_random(70);
		set_all(20'd40000, 16'd300, 16'd2000, 16'hFF00, 16'd10846, 20'hFF127, 16'd300);
		run_random(70);

		$display("%0d samples in, %0d results checked over six register settings",
			items_in, results_seen);
		$display("startup trips %0d, duty clamps %0d, current clips %0d, input stalls %0d",
			boot_trips, duty_clips, amps_clips, stall_seen);
		if (errors == 0 && predicted_q.size() == 0)
			$display("averaged_current_pi_pwm_loop: match");
		else
			$display("averaged_current_pi_pwm_loop: mismatch");
		$finish;
	end

endmodule
